// ----- src/pip_pkg.sv -----
package pip_pkg;

   localparam int VTX_W     = 32;
   localparam int NRM_W     = 18;
   localparam int THR_W     = 31;
   localparam int ALN_W     = 17;
   localparam int IDX_W     = 20;
   localparam int CNT_W     = 21;
   localparam int SCORE_W   = 14;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 32;

   // classification queue between the geometry pipe and the scorer
   localparam int QUEUE_DEPTH = 8;
   localparam int QPTR_W      = 3;

   // score divider: numerator 2000*diff + m - 1 stays below 2^33
   localparam int DIV_W  = 33;
   localparam int DIVC_W = 6;

   localparam int MAX_POINTS_DEF     = 1048576;
   localparam int MIN_INLIERS_DEF    = 40;
   localparam int TARGET_DENSITY_DEF = 150;

   localparam logic [SCORE_W-1:0] SCORE_FULL   = 14'd10000;
   localparam logic [10:0]        SCORE_SPREAD = 11'd2000;
   localparam logic [CNT_W-1:0]   CNT_SAT      = '1;

   localparam logic [CSR_IDX_W-1:0] REG_NORMAL_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_NORMAL_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_NORMAL_Z = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_REF_X    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_REF_Y    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_REF_Z    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_DIST_THR = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_ALIGN    = 3'd7;

   typedef struct packed {
      logic signed [NRM_W-1:0] normal_x;
      logic signed [NRM_W-1:0] normal_y;
      logic signed [NRM_W-1:0] normal_z;
      logic signed [VTX_W-1:0] ref_x;
      logic signed [VTX_W-1:0] ref_y;
      logic signed [VTX_W-1:0] ref_z;
      logic [THR_W-1:0]        dist_threshold;
      logic [ALN_W-1:0]        normal_alignment;
   } cfg_type;

   typedef struct packed {
      logic inlier;
      logic last;
   } class_type;

endpackage

// ----- src/plane_inlier_test_and_score_top.sv -----
// chan  dir  handshake            payload
// req   in   req_valid/req_ready  vertex_x/y/z, point_normal_x/y/z, last_point
// rsp   out  rsp_valid/rsp_ready  point_index, is_inlier, inlier_count, score_valid, plane_score
// csr   in   csr_valid/csr_ready  csr_index, csr_wdata
//
// A request passes a four-stage geometry pipe into an eight-entry classification queue;
// ordinary points sustain one request per cycle while rsp keeps up. A last point whose count passes the
// minimum holds the back end longer than an ordinary point: load, 33 bit-serial divider
// steps, then handoff to the rsp register once it is free.
// Reset is synchronous and active high; it restores the plane registers and clears counters.
// req_ready drops once eight requests are in flight, so rsp stalls back up without loss.
module plane_inlier_test_and_score_top #(
   parameter int MAX_POINTS     = pip_pkg::MAX_POINTS_DEF,
   parameter int MIN_INLIERS    = pip_pkg::MIN_INLIERS_DEF,
   parameter int TARGET_DENSITY = pip_pkg::TARGET_DENSITY_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [pip_pkg::VTX_W-1:0]     req_vertex_x,
   input  logic signed [pip_pkg::VTX_W-1:0]     req_vertex_y,
   input  logic signed [pip_pkg::VTX_W-1:0]     req_vertex_z,
   input  logic signed [pip_pkg::NRM_W-1:0]     req_point_normal_x,
   input  logic signed [pip_pkg::NRM_W-1:0]     req_point_normal_y,
   input  logic signed [pip_pkg::NRM_W-1:0]     req_point_normal_z,
   input  logic                                 req_last_point,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [pip_pkg::IDX_W-1:0]            rsp_point_index,
   output logic                                 rsp_is_inlier,
   output logic [pip_pkg::CNT_W-1:0]            rsp_inlier_count,
   output logic                                 rsp_score_valid,
   output logic [pip_pkg::SCORE_W-1:0]          rsp_plane_score,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [pip_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [pip_pkg::CSR_DAT_W-1:0]        csr_wdata
);
   import pip_pkg::*;

   cfg_type   cfg_ff;
   logic      q_push, q_pop, q_not_empty;
   class_type q_in, q_head;

   // register writes are always taken
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.normal_x         <= '0;
         cfg_ff.normal_y         <= '0;
         cfg_ff.normal_z         <= 18'sd65536;
         cfg_ff.ref_x            <= '0;
         cfg_ff.ref_y            <= '0;
         cfg_ff.ref_z            <= '0;
         cfg_ff.dist_threshold   <= 31'd6554;
         cfg_ff.normal_alignment <= 17'd58982;
      end else if (csr_valid) begin
         case (csr_index)
            REG_NORMAL_X: cfg_ff.normal_x         <= csr_wdata[NRM_W-1:0];
            REG_NORMAL_Y: cfg_ff.normal_y         <= csr_wdata[NRM_W-1:0];
            REG_NORMAL_Z: cfg_ff.normal_z         <= csr_wdata[NRM_W-1:0];
            REG_REF_X:    cfg_ff.ref_x            <= csr_wdata;
            REG_REF_Y:    cfg_ff.ref_y            <= csr_wdata;
            REG_REF_Z:    cfg_ff.ref_z            <= csr_wdata;
            REG_DIST_THR: cfg_ff.dist_threshold   <= csr_wdata[THR_W-1:0];
            REG_ALIGN:    cfg_ff.normal_alignment <= csr_wdata[ALN_W-1:0];
            default: ;
         endcase
      end
   end

   // classify each point: distance and normal alignment tests
   pip_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .vx        (req_vertex_x),
      .vy        (req_vertex_y),
      .vz        (req_vertex_z),
      .nx        (req_point_normal_x),
      .ny        (req_point_normal_y),
      .nz        (req_point_normal_z),
      .last      (req_last_point),
      .pop       (q_pop),
      .push      (q_push),
      .push_item (q_in)
   );

   // hold classified points until the scorer takes them
   pip_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_in),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head      (q_head)
   );

   // advance counters, score the cloud on its last point
   pip_back #(
      .MAX_POINTS     (MAX_POINTS),
      .MIN_INLIERS    (MIN_INLIERS),
      .TARGET_DENSITY (TARGET_DENSITY)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_not_empty),
      .q_item           (q_head),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_point_index  (rsp_point_index),
      .rsp_is_inlier    (rsp_is_inlier),
      .rsp_inlier_count (rsp_inlier_count),
      .rsp_score_valid  (rsp_score_valid),
      .rsp_plane_score  (rsp_plane_score)
   );

endmodule

// ----- src/pip_front.sv -----
module pip_front (
   input  logic                             clock,
   input  logic                             reset,
   input  pip_pkg::cfg_type                 cfg,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic signed [pip_pkg::VTX_W-1:0] vx,
   input  logic signed [pip_pkg::VTX_W-1:0] vy,
   input  logic signed [pip_pkg::VTX_W-1:0] vz,
   input  logic signed [pip_pkg::NRM_W-1:0] nx,
   input  logic signed [pip_pkg::NRM_W-1:0] ny,
   input  logic signed [pip_pkg::NRM_W-1:0] nz,
   input  logic                             last,
   input  logic                             pop,
   output logic                             push,
   output pip_pkg::class_type               push_item
);
   import pip_pkg::*;

   logic accept;
   logic [QPTR_W:0] credit_ff, credit_in;

   // stage A: offsets, normal products, squares
   logic a_vld_ff, a_last_ff;
   logic signed [32:0] dx_ff, dy_ff, dz_ff;
   logic signed [35:0] pnx_ff, pny_ff, pnz_ff;
   logic [34:0] qx_ff, qy_ff, qz_ff;
   logic [33:0] a2_ff;
   logic signed [35:0] pnx_in, pny_in, pnz_in, qx_in, qy_in, qz_in;
   // stage B: distance products, |n.N|, n.n
   logic b_vld_ff, b_last_ff;
   logic signed [50:0] pdx_ff, pdy_ff, pdz_ff;
   logic [35:0] s_ff, nn_ff;
   logic [33:0] a2b_ff;
   logic signed [37:0] dot;
   logic [37:0] dot_mag;
   // stage C: distance sum, split squares
   logic c_vld_ff, c_last_ff;
   logic signed [52:0] d_ff;
   logic [35:0] ss_hh_ff, ss_hl_ff, ss_ll_ff;
   logic [33:0] r_hh_ff, r_hl_ff;
   logic [35:0] r_lh_ff, r_ll_ff;
   // stage D: near flag, wide sides
   logic d_vld_ff, d_last_ff, near_ff;
   logic [71:0] lhs_ff, rhs_ff;
   logic [52:0] d_mag;

   assign req_ready = credit_ff < (QPTR_W+1)'(QUEUE_DEPTH);
   assign accept    = req_valid && req_ready;
   assign credit_in = credit_ff + (QPTR_W+1)'(accept) - (QPTR_W+1)'(pop);

   assign pnx_in = nx * cfg.normal_x;
   assign pny_in = ny * cfg.normal_y;
   assign pnz_in = nz * cfg.normal_z;
   assign qx_in  = nx * nx;
   assign qy_in  = ny * ny;
   assign qz_in  = nz * nz;

   assign dot     = 38'(pnx_ff) + 38'(pny_ff) + 38'(pnz_ff);
   assign dot_mag = dot[37] ? 38'(-dot) : 38'(dot);
   assign d_mag   = d_ff[52] ? 53'(-d_ff) : 53'(d_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff <= '0;
         a_vld_ff  <= 1'b0;
         b_vld_ff  <= 1'b0;
         c_vld_ff  <= 1'b0;
         d_vld_ff  <= 1'b0;
      end else begin
         credit_ff <= credit_in;
         a_vld_ff  <= accept;
         b_vld_ff  <= a_vld_ff;
         c_vld_ff  <= b_vld_ff;
         d_vld_ff  <= c_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_last_ff <= last;
      dx_ff     <= 33'(vx) - 33'(cfg.ref_x);
      dy_ff     <= 33'(vy) - 33'(cfg.ref_y);
      dz_ff     <= 33'(vz) - 33'(cfg.ref_z);
      pnx_ff    <= pnx_in;
      pny_ff    <= pny_in;
      pnz_ff    <= pnz_in;
      qx_ff     <= qx_in[34:0];
      qy_ff     <= qy_in[34:0];
      qz_ff     <= qz_in[34:0];
      a2_ff     <= cfg.normal_alignment * cfg.normal_alignment;

      b_last_ff <= a_last_ff;
      pdx_ff    <= dx_ff * cfg.normal_x;
      pdy_ff    <= dy_ff * cfg.normal_y;
      pdz_ff    <= dz_ff * cfg.normal_z;
      s_ff      <= dot_mag[35:0];
      nn_ff     <= 36'(qx_ff) + 36'(qy_ff) + 36'(qz_ff);
      a2b_ff    <= a2_ff;

      c_last_ff <= b_last_ff;
      d_ff      <= 53'(pdx_ff) + 53'(pdy_ff) + 53'(pdz_ff);
      ss_hh_ff  <= s_ff[35:18] * s_ff[35:18];
      ss_hl_ff  <= s_ff[35:18] * s_ff[17:0];
      ss_ll_ff  <= s_ff[17:0] * s_ff[17:0];
      r_hh_ff   <= a2b_ff[33:18] * nn_ff[35:18];
      r_hl_ff   <= a2b_ff[33:18] * nn_ff[17:0];
      r_lh_ff   <= a2b_ff[17:0] * nn_ff[35:18];
      r_ll_ff   <= a2b_ff[17:0] * nn_ff[17:0];

      d_last_ff <= c_last_ff;
      near_ff   <= d_mag < 53'({cfg.dist_threshold, 16'b0});
      lhs_ff    <= (72'(ss_hh_ff) << 36) + (72'(ss_hl_ff) << 19) + 72'(ss_ll_ff);
      rhs_ff    <= (72'(r_hh_ff) << 36) + (72'(r_hl_ff) << 18)
                 + (72'(r_lh_ff) << 18) + 72'(r_ll_ff);
   end

   assign push             = d_vld_ff;
   assign push_item.inlier = near_ff && (lhs_ff > rhs_ff);
   assign push_item.last   = d_last_ff;

endmodule

// ----- src/pip_queue.sv -----
module pip_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  pip_pkg::class_type push_item,
   input  logic               pop,
   output logic               not_empty,
   output pip_pkg::class_type head
);
   import pip_pkg::*;

   class_type            slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]    wr_ff, rd_ff;
   logic [QPTR_W:0]      count_ff;

   assign not_empty = count_ff != '0;
   assign head      = slot_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop) rd_ff <= rd_ff + 1'b1;
         count_ff <= count_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= push_item;
   end

endmodule

// ----- src/pip_back.sv -----
module pip_back #(
   parameter int MAX_POINTS     = pip_pkg::MAX_POINTS_DEF,
   parameter int MIN_INLIERS    = pip_pkg::MIN_INLIERS_DEF,
   parameter int TARGET_DENSITY = pip_pkg::TARGET_DENSITY_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             q_valid,
   input  pip_pkg::class_type               q_item,
   output logic                             q_pop,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [pip_pkg::IDX_W-1:0]        rsp_point_index,
   output logic                             rsp_is_inlier,
   output logic [pip_pkg::CNT_W-1:0]        rsp_inlier_count,
   output logic                             rsp_score_valid,
   output logic [pip_pkg::SCORE_W-1:0]      rsp_plane_score
);
   import pip_pkg::*;

   localparam int PC_W = $clog2(MAX_POINTS);
   localparam logic [PC_W-1:0]  PC_LAST  = PC_W'(MAX_POINTS - 1);
   localparam logic [CNT_W-1:0] MIN_C    = CNT_W'(MIN_INLIERS);
   localparam logic [CNT_W-1:0] TARGET_C = CNT_W'(TARGET_DENSITY);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_OUT  = 2'd2;

   logic [1:0]        state_ff;
   logic [PC_W-1:0]   pcnt_ff;
   logic [CNT_W-1:0]  icnt_ff, cnt_upd, diff, m_sel;
   logic              out_free, scoring, load_now, load_div;
   logic [PC_W+IDX_W-1:0] idx_wide;

   logic [DIV_W-1:0]  num_ff;
   logic [CNT_W-1:0]  rem_ff, m_ff;
   logic [DIVC_W-1:0] iter_ff;
   logic [CNT_W:0]    rem_sh, rem_sub;
   logic              ge;

   logic [IDX_W-1:0]  p_idx_ff;
   logic              p_inl_ff;
   logic [CNT_W-1:0]  p_cnt_ff;

   logic              rsp_valid_ff, rsp_inl_ff, rsp_sv_ff;
   logic [IDX_W-1:0]  rsp_idx_ff;
   logic [CNT_W-1:0]  rsp_cnt_ff;
   logic [SCORE_W-1:0] rsp_score_ff;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign q_pop    = (state_ff == ST_IDLE) && q_valid && out_free;
   assign cnt_upd  = (q_item.inlier && icnt_ff != CNT_SAT) ? icnt_ff + 1'b1 : icnt_ff;
   assign scoring  = q_item.last && (cnt_upd > MIN_C);
   assign diff     = (cnt_upd > TARGET_C) ? cnt_upd - TARGET_C : TARGET_C - cnt_upd;
   assign m_sel    = (cnt_upd > TARGET_C) ? cnt_upd : TARGET_C;
   assign idx_wide = {IDX_W'(0), pcnt_ff};
   assign load_now = q_pop && !scoring;
   assign load_div = (state_ff == ST_OUT) && out_free;

   assign rem_sh  = {rem_ff, num_ff[DIV_W-1]};
   assign rem_sub = rem_sh - {1'b0, m_ff};
   assign ge      = rem_sh >= {1'b0, m_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pcnt_ff      <= '0;
         icnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         iter_ff      <= '0;
      end else begin
         if (load_now || load_div) rsp_valid_ff <= 1'b1;
         else if (rsp_ready)       rsp_valid_ff <= 1'b0;
         if (q_pop) begin
            // restart both counters after the last point of a cloud
            if (q_item.last) begin
               pcnt_ff <= '0;
               icnt_ff <= '0;
            end else begin
               pcnt_ff <= (pcnt_ff == PC_LAST) ? '0 : pcnt_ff + 1'b1;
               icnt_ff <= cnt_upd;
            end
         end
         case (state_ff)
            ST_IDLE: begin
               if (q_pop && scoring) begin
                  state_ff <= ST_DIV;
                  iter_ff  <= '0;
               end
            end
            ST_DIV: begin
               iter_ff <= iter_ff + 1'b1;
               if (iter_ff == DIVC_W'(DIV_W - 1)) state_ff <= ST_OUT;
            end
            ST_OUT: begin
               if (out_free) state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         p_idx_ff <= idx_wide[IDX_W-1:0];
         p_inl_ff <= q_item.inlier;
         p_cnt_ff <= cnt_upd;
         // ceiling quotient: divide 2000*diff + m - 1 by m
         num_ff   <= DIV_W'(diff) * DIV_W'(SCORE_SPREAD) + DIV_W'(m_sel) - 1'b1;
         rem_ff   <= '0;
         m_ff     <= m_sel;
      end else if (state_ff == ST_DIV) begin
         rem_ff <= ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
         num_ff <= {num_ff[DIV_W-2:0], ge};
      end
      if (load_now) begin
         rsp_idx_ff   <= idx_wide[IDX_W-1:0];
         rsp_inl_ff   <= q_item.inlier;
         rsp_cnt_ff   <= cnt_upd;
         rsp_sv_ff    <= q_item.last;
         rsp_score_ff <= '0;
      end else if (load_div) begin
         rsp_idx_ff   <= p_idx_ff;
         rsp_inl_ff   <= p_inl_ff;
         rsp_cnt_ff   <= p_cnt_ff;
         rsp_sv_ff    <= 1'b1;
         rsp_score_ff <= SCORE_FULL - num_ff[SCORE_W-1:0];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_point_index  = rsp_idx_ff;
   assign rsp_is_inlier    = rsp_inl_ff;
   assign rsp_inlier_count = rsp_cnt_ff;
   assign rsp_score_valid  = rsp_sv_ff;
   assign rsp_plane_score  = rsp_score_ff;

endmodule

// ----- verif/tb_top.sv -----
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import pip_pkg::*;

   typedef struct {
      logic signed [VTX_W-1:0] vx, vy, vz;
      logic signed [NRM_W-1:0] nx, ny, nz;
      logic                    last;
   } point_type;

   typedef struct {
      logic [IDX_W-1:0]   index;
      logic               inlier;
      logic [CNT_W-1:0]   count;
      logic               score_valid;
      logic [SCORE_W-1:0] score;
   } verdict_type;

   localparam int CYCLE_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset;

   logic                    req_valid;
   logic                    req_ready;
   logic signed [VTX_W-1:0] req_vertex_x, req_vertex_y, req_vertex_z;
   logic signed [NRM_W-1:0] req_point_normal_x, req_point_normal_y, req_point_normal_z;
   logic                    req_last_point;
   logic                    rsp_valid;
   logic                    rsp_ready;
   logic [IDX_W-1:0]        rsp_point_index;
   logic                    rsp_is_inlier;
   logic [CNT_W-1:0]        rsp_inlier_count;
   logic                    rsp_score_valid;
   logic [SCORE_W-1:0]      rsp_plane_score;
   logic                    csr_valid;
   logic                    csr_ready;
   logic [CSR_IDX_W-1:0]    csr_index;
   logic [CSR_DAT_W-1:0]    csr_wdata;

   plane_inlier_test_and_score_top DUT (.*);

   // plane copy kept by the scoreboard
   logic signed [NRM_W-1:0] plane_nx, plane_ny, plane_nz;
   logic signed [VTX_W-1:0] origin_x, origin_y, origin_z;
   logic [THR_W-1:0]        max_dist;
   logic [ALN_W-1:0]        min_cos;
   logic [IDX_W-1:0]        points_seen;
   logic [CNT_W-1:0]        inliers_seen;

   point_type   pending_points[$];
   verdict_type expected_verdicts[$];

   int  idle_pct = 0;
   int  stall_pct = 0;
   int  hold_request = 0;
   int  hold_ack = 0;
   int  hold_left = 0;
   int  errors = 0;
   int  cycles = 0;
   int  points_sent = 0;
   int  verdicts_checked = 0;
   int  inliers_checked = 0;
   int  scores_checked = 0;

   always #2 clock = ~clock;

   // Compute the verdict for one accepted point and advance the cloud counters.
   function automatic verdict_type classify_point(point_type p);
      verdict_type v;
      longint      plane_dist, dot;
      longint      abs_dist;
      logic [127:0] dot_abs, norm_sq, cos_sq, lhs, rhs;
      longint      c, diff, m;
      logic        near_plane, aligned;
      plane_dist = (longint'(p.vx) - longint'(origin_x)) * longint'(plane_nx)
                 + (longint'(p.vy) - longint'(origin_y)) * longint'(plane_ny)
                 + (longint'(p.vz) - longint'(origin_z)) * longint'(plane_nz);
      abs_dist = plane_dist < 0 ? -plane_dist : plane_dist;
      near_plane = abs_dist < (longint'(max_dist) <<< 16);
      dot = longint'(p.nx) * longint'(plane_nx) + longint'(p.ny) * longint'(plane_ny)
          + longint'(p.nz) * longint'(plane_nz);
      dot_abs = dot < 0 ? 128'(-dot) : 128'(dot);
      norm_sq = 128'(longint'(p.nx) * longint'(p.nx) + longint'(p.ny) * longint'(p.ny)
                     + longint'(p.nz) * longint'(p.nz));
      cos_sq = 128'(min_cos) * 128'(min_cos);
      lhs = dot_abs * dot_abs;
      rhs = cos_sq * norm_sq;
      aligned = lhs > rhs;
      v.inlier = near_plane && aligned;
      v.index = points_seen;
      if (v.inlier && inliers_seen != CNT_SAT) inliers_seen++;
      v.count = inliers_seen;
      v.score_valid = p.last;
      v.score = '0;
      if (p.last && inliers_seen > CNT_W'(MIN_INLIERS_DEF)) begin
         c = longint'(inliers_seen);
         diff = c > TARGET_DENSITY_DEF ? c - TARGET_DENSITY_DEF : TARGET_DENSITY_DEF - c;
         m = c > TARGET_DENSITY_DEF ? c : TARGET_DENSITY_DEF;
         v.score = SCORE_W'(10000 - (2000 * diff + m - 1) / m);
      end
      if (p.last) begin
         points_seen = '0;
         inliers_seen = '0;
      end else begin
         points_seen++;
      end
      return v;
   endfunction

   // Request driver: hold a pending point until accepted, then pull the next one.
   always @(posedge clock) begin
      point_type nxt;
      logic      free;
      cycles <= cycles + 1;
      if (!reset) begin
         free = !req_valid;
         if (req_valid && req_ready) begin
            expected_verdicts.push_back(classify_point('{req_vertex_x, req_vertex_y,
               req_vertex_z, req_point_normal_x, req_point_normal_y, req_point_normal_z,
               req_last_point}));
            points_sent++;
            free = 1'b1;
         end
         if (free) begin
            if (pending_points.size() > 0 && $urandom_range(99) >= idle_pct) begin
               nxt = pending_points.pop_front();
               req_valid          <= 1'b1;
               req_vertex_x       <= nxt.vx;
               req_vertex_y       <= nxt.vy;
               req_vertex_z       <= nxt.vz;
               req_point_normal_x <= nxt.nx;
               req_point_normal_y <= nxt.ny;
               req_point_normal_z <= nxt.nz;
               req_last_point     <= nxt.last;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: check against the oldest verdict, then pick the next ready level.
   always @(posedge clock) begin
      verdict_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_verdicts.size() == 0) begin
               $display("%0t: unexpected result, index %0d", $realtime, rsp_point_index);
               errors++;
            end else begin
               want = expected_verdicts.pop_front();
               verdicts_checked++;
               if (rsp_is_inlier) inliers_checked++;
               if (rsp_score_valid) scores_checked++;
               if (rsp_point_index !== want.index) begin
                  $display("%0t: point_index expected %0d actual %0d", $realtime,
                           want.index, rsp_point_index);
                  errors++;
               end
               if (rsp_is_inlier !== want.inlier) begin
                  $display("%0t: is_inlier expected %0d actual %0d (index %0d)", $realtime,
                           want.inlier, rsp_is_inlier, want.index);
                  errors++;
               end
               if (rsp_inlier_count !== want.count) begin
                  $display("%0t: inlier_count expected %0d actual %0d", $realtime,
                           want.count, rsp_inlier_count);
                  errors++;
               end
               if (rsp_score_valid !== want.score_valid) begin
                  $display("%0t: score_valid expected %0d actual %0d", $realtime,
                           want.score_valid, rsp_score_valid);
                  errors++;
               end
               if (rsp_plane_score !== want.score) begin
                  $display("%0t: plane_score expected %0d actual %0d", $realtime,
                           want.score, rsp_plane_score);
                  errors++;
               end
            end
         end
         // A long hold-off lets the queue fill so req_ready has to drop.
         if (hold_request != hold_ack) begin
            hold_ack = hold_request;
            hold_left = 300;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $realtime,
                  expected_verdicts.size());
         $display("** plane_inlier_test_and_score_top: FAILED **");
         $finish;
      end
   end

   // Wait until every request has drained, then let the score divider settle.
   task automatic drain();
      while (pending_points.size() > 0 || req_valid || expected_verdicts.size() > 0)
         @(negedge clock);
      repeat (60) @(negedge clock);
   endtask

   // Write one plane register and mirror it into the scoreboard copy.
   task automatic write_plane_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DAT_W-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         REG_NORMAL_X: plane_nx = data[NRM_W-1:0];
         REG_NORMAL_Y: plane_ny = data[NRM_W-1:0];
         REG_NORMAL_Z: plane_nz = data[NRM_W-1:0];
         REG_REF_X:    origin_x = data;
         REG_REF_Y:    origin_y = data;
         REG_REF_Z:    origin_z = data;
         REG_DIST_THR: max_dist = data[THR_W-1:0];
         REG_ALIGN:    min_cos  = data[ALN_W-1:0];
         default: ;
      endcase
   endtask

   task automatic set_plane(int nx, int ny, int nz, int rx, int ry, int rz, int thr,
                            int cosv);
      drain();
      write_plane_reg(REG_NORMAL_X, nx);
      write_plane_reg(REG_NORMAL_Y, ny);
      write_plane_reg(REG_NORMAL_Z, nz);
      write_plane_reg(REG_REF_X, rx);
      write_plane_reg(REG_REF_Y, ry);
      write_plane_reg(REG_REF_Z, rz);
      write_plane_reg(REG_DIST_THR, thr);
      write_plane_reg(REG_ALIGN, cosv);
   endtask

   function automatic point_type raw_point(int vx, int vy, int vz, int nx, int ny, int nz,
                                           bit last);
      point_type p;
      p.vx = vx; p.vy = vy; p.vz = vz;
      p.nx = nx; p.ny = ny; p.nz = nz;
      p.last = last;
      return p;
   endfunction

   function automatic point_type noise_point(bit last);
      point_type p;
      p.vx = $urandom; p.vy = $urandom; p.vz = $urandom;
      p.nx = $urandom; p.ny = $urandom; p.nz = $urandom;
      p.last = last;
      return p;
   endfunction

   // Queue a cloud: good_pct percent of the points sit close to the plane with a nearly
   // parallel normal, the rest are noise.
   task automatic queue_cloud(int size, int good_pct);
      point_type p;
      for (int i = 0; i < size; i++) begin
         if ($urandom_range(99) < good_pct) begin
            p.vx = origin_x + (int'($urandom_range(2000)) - 1000);
            p.vy = origin_y + (int'($urandom_range(2000)) - 1000);
            p.vz = origin_z + (int'($urandom_range(2000)) - 1000);
            p.nx = plane_nx + (int'($urandom_range(4000)) - 2000);
            p.ny = plane_ny + (int'($urandom_range(4000)) - 2000);
            p.nz = plane_nz + (int'($urandom_range(4000)) - 2000);
            p.last = (i == size - 1);
         end else begin
            p = noise_point(i == size - 1);
         end
         pending_points.push_back(p);
      end
   endtask

   function automatic int cloud_size();
      int r;
      r = $urandom_range(99);
      if (r < 15) return $urandom_range(1, 10);
      if (r < 85) return $urandom_range(10, 25);
      return $urandom_range(30, 60);
   endfunction

   initial begin
      reset              <= 1'b1;
      req_valid          <= 1'b0;
      req_vertex_x       <= '0;
      req_vertex_y       <= '0;
      req_vertex_z       <= '0;
      req_point_normal_x <= '0;
      req_point_normal_y <= '0;
      req_point_normal_z <= '0;
      req_last_point     <= 1'b0;
      rsp_ready          <= 1'b0;
      csr_valid          <= 1'b0;
      csr_index          <= '0;
      csr_wdata          <= '0;
      plane_nx = 0; plane_ny = 0; plane_nz = 65536;
      origin_x = 0; origin_y = 0; origin_z = 0;
      max_dist = 6554; min_cos = 58982;
      points_seen = '0; inliers_seen = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed points on the reset plane (z = 0, normal +z).
      pending_points.push_back(raw_point(0, 0, 0, 0, 0, 65536, 0));
      pending_points.push_back(raw_point(0, 0, 0, 0, 0, -65536, 0));
      pending_points.push_back(raw_point(0, 0, 0, 0, 0, 0, 0));          // zero normal
      pending_points.push_back(raw_point(32'h7FFFFFFF, 32'h80000000, 6553, 0, 0, 65536, 0));
      pending_points.push_back(raw_point(0, 0, 6554, 0, 0, 65536, 0));   // on the bound
      pending_points.push_back(raw_point(0, 0, -6553, 1000, 0, 65536, 0));
      pending_points.push_back(raw_point(0, 0, 0, 65536, 0, 65536, 0));  // 45 degrees
      pending_points.push_back(raw_point(0, 0, 32'h7FFFFFFF, 0, 0, 65536, 0));
      pending_points.push_back(raw_point(0, 0, 32'h80000000, -131072, 131071, -131072, 0));
      pending_points.push_back(raw_point(0, 0, 0, -65536, -65536, 131071, 1));
      pending_points.push_back(raw_point(0, 0, 0, 0, 0, 65536, 1));     // one-point cloud
      drain();

      // Extremes: zero plane normal, widest threshold, zero cosine bound.
      set_plane(0, 0, 0, 32'h80000000, 32'h7FFFFFFF, 0, 32'h7FFFFFFF, 0);
      for (int i = 0; i < 6; i++) pending_points.push_back(noise_point(i == 5));
      // Full-scale -x normal, zero threshold, cosine bound of one.
      set_plane(-65536, 0, 0, 12345, -777, 3, 0, 65536);
      for (int i = 0; i < 4; i++) pending_points.push_back(noise_point(i == 3));
      pending_points.push_back(raw_point(12345, 0, 0, -65536, 0, 0, 1));
      // Widest threshold and loose cosine on the x plane so most points count.
      set_plane(-65536, 0, 0, 12345, -777, 3, 32'h7FFFFFFF, 0);
      queue_cloud(160, 100);                    // count above target

      // Random phases, one plane and one idling mix each.
      for (int phase = 0; phase < 8; phase++) begin
         case (phase % 4)
            0: set_plane(0, 0, 65536, $urandom, $urandom, $urandom_range(200000), 6554, 58982);
            1: set_plane(46341, 0, 46341, $urandom_range(100000), 0, -5000, 
                         $urandom_range(20000, 300000), $urandom_range(40000, 65000));
            2: set_plane(0, -65536, 0, $urandom, $urandom, $urandom, $urandom_range(7000),
                         $urandom_range(65536));
            default: set_plane($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                               $urandom, $urandom);
         endcase
         @(negedge clock);
         case (phase % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 52; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 52; end
            default: begin idle_pct = 10; stall_pct = 10; end
         endcase
         queue_cloud(cloud_size(), 80);
         if (phase == 2) begin
            // Hold rsp off for a long stretch while requests keep coming.
            queue_cloud(40, 80);
            hold_request++;
         end
         queue_cloud(cloud_size(), 75);
         queue_cloud($urandom_range(1, 8), 20);
      end
      // Sender stops here until every result is back.
      drain();
      idle_pct = 0; stall_pct = 0;
      set_plane(0, 0, 65536, 0, 0, 0, 6554, 58982);
      queue_cloud(41, 100);
      queue_cloud(150, 100);
      drain();

      $display("Checked %0d results (%0d inliers, %0d plane scores) over %0d requests,",
               verdicts_checked, inliers_checked, scores_checked, points_sent);
      $display("across plane settings and idling mixes including a long result stall.");
      if (errors == 0)
         $display("** plane_inlier_test_and_score_top: PASSED **");
      else
         $display("** plane_inlier_test_and_score_top: FAILED **");
      $finish;
   end

endmodule
